/* rtl/pfds_pkg.sv */
package pfds_pkg;

    // Fixed-point constants, all Q16.16
    localparam logic [17:0] Q_PI          = 18'd205887;
    localparam logic [16:0] Q_FOUR_THIRDS = 17'd87381;
    localparam logic [15:0] Q_CUT         = 16'd52429;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_BODY_X = 3'd0;
    localparam logic [2:0] REG_BODY_Y = 3'd1;
    localparam logic [2:0] REG_BODY_Z = 3'd2;
    localparam logic [2:0] REG_DENS   = 3'd3;
    localparam logic [2:0] REG_LIN    = 3'd4;
    localparam logic [2:0] REG_QUAD   = 3'd5;

    // Register reset values
    localparam logic signed [31:0] RST_BODY_Z = -32'sd642908;
    localparam logic [30:0]        RST_DENS   = 31'd80478;

    // Latency of the root and quotient pipelines
    localparam int SQ_LAT = 32;
    localparam int DV_LAT = 16;

    typedef struct packed {
        logic               alive;
        logic [30:0]        radius;
        logic [30:0]        mass;
        logic [30:0]        inverse_mass;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] wind_x;
        logic signed [31:0] wind_y;
        logic signed [31:0] wind_z;
        logic [15:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               drag_step_limited;
    } t_out_item;

    typedef logic signed [31:0] t_vec3 [3];

    // Round an unsigned Q32.32 product to Q16.16, saturate to 31 bits
    function automatic logic [30:0] rnd_u31(input logic [63:0] x);
        logic [63:0] t;
        t = (x + 64'd32768) >> 16;
        return (t > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : t[30:0];
    endfunction

    // Round a signed Q32.32 product to Q16.16, ties toward plus infinity
    function automatic logic signed [63:0] rnd_s(input logic signed [63:0] x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // Magnitude of a signed 32-bit value
    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage

/* rtl/pfds_sqrt.sv */
module pfds_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);
    import pfds_pkg::*;

    logic [63:0] r_rem  [SQ_LAT];
    logic [31:0] r_root [SQ_LAT];

    // One root bit per stage, most significant first
    for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
        localparam int B = SQ_LAT - 1 - k;
        logic [63:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] cand;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign cand = (64'(root_in) << (B + 1)) | (64'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (rem_in >= cand) begin
                r_rem[k]  <= rem_in - cand;
                r_root[k] <= root_in | (32'd1 << B);
            end else begin
                r_rem[k]  <= rem_in;
                r_root[k] <= root_in;
            end
        end
    end

    assign o_root = r_root[SQ_LAT-1];

endmodule

/* rtl/pfds_div.sv */
module pfds_div (
    input  logic        i_clk,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic [15:0] o_quo
);
    import pfds_pkg::*;

    logic [47:0] r_rem [DV_LAT];
    logic [31:0] r_den [DV_LAT];
    logic [15:0] r_quo [DV_LAT];

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < DV_LAT; k++) begin : g_stage
        localparam int B = DV_LAT - 1 - k;
        logic [47:0] rem_in;
        logic [31:0] den_in;
        logic [15:0] quo_in;
        logic [47:0] sub;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign sub = 48'(den_in) << B;

        always_ff @(posedge i_clk) begin
            r_den[k] <= den_in;
            if (rem_in >= sub) begin
                r_rem[k] <= rem_in - sub;
                r_quo[k] <= quo_in | (16'd1 << B);
            end else begin
                r_rem[k] <= rem_in;
                r_quo[k] <= quo_in;
            end
        end
    end

    assign o_quo = r_quo[DV_LAT-1];

endmodule

/* rtl/particle_fluid_drag_step_top.sv */
// Particle velocity update with buoyancy and linear plus quadratic drag, in Q16.16.
// Pulse start with one particle on i_item; busy stays low, so a particle may be
// issued every clock. The updated velocity appears on o_result with o_valid high
// for one cycle, in issue order; the receiver must take it then. The latency is set
// by two 32-stage square root pipelines (relative wind speed, drag acceleration
// magnitude) and a 16-stage divider for the cut drag step, plus the multiply
// stages around them. Write the six registers on i_cfg_* only while no particle
// is in flight.
module particle_fluid_drag_step_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pfds_pkg::t_in_item   i_item,
    output logic                 o_valid,
    output pfds_pkg::t_out_item  o_result,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    import pfds_pkg::*;

    localparam int D1  = SQ_LAT - 5;
    localparam int D2  = SQ_LAT;
    localparam int LAT = 8 + D1 + 7 + D2 + 1 + DV_LAT + 2;

    typedef struct packed {
        logic               alive;
        logic signed [31:0] vx, vy, vz;
        logic signed [31:0] rx, ry, rz;
        logic [30:0]        inv;
        logic [15:0]        dt;
    } t_carry;

    typedef struct packed {
        t_carry             c;
        logic [30:0]        area;
        logic signed [31:0] gx, gy, gz;
    } t_mid;

    typedef struct packed {
        logic               alive;
        logic signed [31:0] vx, vy, vz;
        logic signed [31:0] gx, gy, gz;
        logic signed [31:0] wx, wy, wz;
        logic [15:0]        dt;
        logic [31:0]        rel_len;
    } t_late;

    typedef struct packed {
        logic               alive;
        logic               lim;
        logic signed [31:0] vx, vy, vz;
        logic signed [31:0] wx, wy, wz;
        logic signed [48:0] gdx, gdy, gdz;
        logic [15:0]        dt;
    } t_tail;

    typedef struct packed {
        logic               alive;
        logic               lim;
        logic [15:0]        cdt;
        logic [15:0]        dt;
        logic signed [31:0] vx, vy, vz;
        logic signed [33:0] gqx, gqy, gqz;
        logic signed [48:0] mdx, mdy, mdz;
    } t_fin;

    // Configuration registers
    logic signed [31:0] r_body [3];
    logic [30:0]        r_dens, r_lin, r_quad;

    logic [LAT-1:0]     r_vld;

    // Buoyancy chain and relative wind
    t_carry             r1_c, r2_c, r3_c, r4_c, r5_c, r6_c, r7_c, r8_c;
    logic [30:0]        r1_r, r2_r;
    logic [30:0]        r1_mass, r2_mass, r3_mass, r4_mass, r5_mass;
    logic [48:0]        r1_mpr;
    logic [61:0]        r2_marea, r3_mar, r5_mdisp;
    logic [63:0]        r2_sq [3];
    logic [63:0]        r3_rel2;
    logic [30:0]        r3_area, r4_area, r5_area, r6_area, r7_area, r8_area;
    logic [47:0]        r4_mvol;
    logic signed [63:0] r6_mfac;
    logic signed [63:0] r7_mag [3];
    logic signed [31:0] r8_ag [3];
    t_mid               r_dly1 [D1];

    // Drag chain
    logic [31:0]        w_rel_len;
    t_mid               r_b1, r_b2, r_b3, r_b4;
    logic [31:0]        r_b1_len, r_b2_len, r_b3_len, r_b4_len;
    logic [61:0]        r_b1_mq, r_b2_mk;
    logic signed [63:0] r_b3_mf [3];
    logic signed [63:0] r_b4_mwa [3];
    t_late              r_b5, r_b6, r_b7;
    logic [63:0]        r_b6_sq [3];
    logic [63:0]        r_b7_wa2;
    t_late              r_dly2 [D2];

    // Step limit and final sum
    logic [31:0]        w_acc_len;
    t_tail              r_c1;
    logic [47:0]        r_c1_num;
    logic [31:0]        r_c1_den;
    t_tail              r_dly3 [DV_LAT];
    logic [15:0]        w_quo;
    t_fin               r_d1;

    logic [15:0]        n_cdt;
    logic signed [31:0] n_ag [3];
    logic signed [31:0] n_f [3];
    logic signed [31:0] n_wa [3];
    logic [30:0]        n_speed, n_coef, n_k, n_fac_area;
    logic [31:0]        n_coef_sum;
    logic signed [31:0] n_fac;
    logic signed [31:0] n_rel [3];
    logic signed [31:0] n_nv [3];
    logic               n_lim;
    t_out_item          n_res;

    assign busy = 1'b0;

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body[0] <= '0;
            r_body[1] <= '0;
            r_body[2] <= RST_BODY_Z;
            r_dens    <= RST_DENS;
            r_lin     <= '0;
            r_quad    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BODY_X: r_body[0] <= i_cfg_data;
                REG_BODY_Y: r_body[1] <= i_cfg_data;
                REG_BODY_Z: r_body[2] <= i_cfg_data;
                REG_DENS:   r_dens    <= i_cfg_data[30:0];
                REG_LIN:    r_lin     <= i_cfg_data[30:0];
                REG_QUAD:   r_quad    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign n_rel[0] = sat_s32(64'(i_item.vel_x) - 64'(i_item.wind_x));
    assign n_rel[1] = sat_s32(64'(i_item.vel_y) - 64'(i_item.wind_y));
    assign n_rel[2] = sat_s32(64'(i_item.vel_z) - 64'(i_item.wind_z));

    assign n_fac_area = rnd_u31(64'(r1_mpr));
    assign n_fac = sat_s32(rnd_s(r6_mfac));
    for (genvar i = 0; i < 3; i++) begin : g_ag
        assign n_ag[i] = sat_s32(rnd_s(r7_mag[i]));
    end

    // Area, volume, buoyancy factor and body acceleration
    always_ff @(posedge i_clk) begin
        r1_c.alive <= i_item.alive;
        r1_c.vx    <= i_item.vel_x;
        r1_c.vy    <= i_item.vel_y;
        r1_c.vz    <= i_item.vel_z;
        r1_c.rx    <= n_rel[0];
        r1_c.ry    <= n_rel[1];
        r1_c.rz    <= n_rel[2];
        r1_c.inv   <= i_item.inverse_mass;
        r1_c.dt    <= i_item.time_step;
        r1_r       <= i_item.radius;
        r1_mass    <= i_item.mass;
        r1_mpr     <= 49'(Q_PI) * 49'(i_item.radius);

        r2_c     <= r1_c;
        r2_r     <= r1_r;
        r2_mass  <= r1_mass;
        r2_marea <= 62'(n_fac_area) * 62'(r1_r);
        r2_sq[0] <= 64'(abs32(r1_c.rx)) * 64'(abs32(r1_c.rx));
        r2_sq[1] <= 64'(abs32(r1_c.ry)) * 64'(abs32(r1_c.ry));
        r2_sq[2] <= 64'(abs32(r1_c.rz)) * 64'(abs32(r1_c.rz));

        r3_c    <= r2_c;
        r3_mass <= r2_mass;
        r3_area <= rnd_u31(64'(r2_marea));
        r3_rel2 <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        r3_mar  <= 62'(rnd_u31(64'(r2_marea))) * 62'(r2_r);

        r4_c    <= r3_c;
        r4_mass <= r3_mass;
        r4_area <= r3_area;
        r4_mvol <= 48'(rnd_u31(64'(r3_mar))) * 48'(Q_FOUR_THIRDS);

        r5_c     <= r4_c;
        r5_mass  <= r4_mass;
        r5_area  <= r4_area;
        r5_mdisp <= 62'(r_dens) * 62'(rnd_u31(64'(r4_mvol)));

        r6_c    <= r5_c;
        r6_area <= r5_area;
        r6_mfac <= 64'($signed(32'(r5_mass) - 32'(rnd_u31(64'(r5_mdisp)))))
                   * 64'($signed({1'b0, r5_c.inv}));

        r7_c    <= r6_c;
        r7_area <= r6_area;
        for (int i = 0; i < 3; i++) begin
            r7_mag[i] <= 64'(r_body[i]) * 64'(n_fac);
        end

        r8_c    <= r7_c;
        r8_area <= r7_area;
        for (int i = 0; i < 3; i++) begin
            r8_ag[i] <= n_ag[i];
        end
    end

    // Hold the particle while the wind speed root settles
    always_ff @(posedge i_clk) begin
        r_dly1[0].c    <= r8_c;
        r_dly1[0].area <= r8_area;
        r_dly1[0].gx   <= r8_ag[0];
        r_dly1[0].gy   <= r8_ag[1];
        r_dly1[0].gz   <= r8_ag[2];
        for (int j = 1; j < D1; j++) begin
            r_dly1[j] <= r_dly1[j-1];
        end
    end

    pfds_sqrt u_sqrt_rel (
        .i_clk  (i_clk),
        .i_rad  (r3_rel2),
        .o_root (w_rel_len)
    );

    assign n_speed    = w_rel_len[31] ? 31'h7FFF_FFFF : w_rel_len[30:0];
    assign n_coef_sum = 32'(r_lin) + 32'(rnd_u31(64'(r_b1_mq)));
    assign n_coef     = n_coef_sum[31] ? 31'h7FFF_FFFF : n_coef_sum[30:0];
    assign n_k        = rnd_u31(64'(r_b2_mk));
    for (genvar i = 0; i < 3; i++) begin : g_wa
        assign n_f[i]  = sat_s32(-rnd_s(r_b3_mf[i]));
        assign n_wa[i] = sat_s32(rnd_s(r_b4_mwa[i]));
    end

    // Drag coefficient, drag force and drag acceleration
    always_ff @(posedge i_clk) begin
        r_b1     <= r_dly1[D1-1];
        r_b1_len <= w_rel_len;
        r_b1_mq  <= 62'(r_quad) * 62'(n_speed);

        r_b2     <= r_b1;
        r_b2_len <= r_b1_len;
        r_b2_mk  <= 62'(r_b1.area) * 62'(n_coef);

        r_b3       <= r_b2;
        r_b3_len   <= r_b2_len;
        r_b3_mf[0] <= 64'(r_b2.c.rx) * 64'($signed({1'b0, n_k}));
        r_b3_mf[1] <= 64'(r_b2.c.ry) * 64'($signed({1'b0, n_k}));
        r_b3_mf[2] <= 64'(r_b2.c.rz) * 64'($signed({1'b0, n_k}));

        r_b4     <= r_b3;
        r_b4_len <= r_b3_len;
        for (int i = 0; i < 3; i++) begin
            r_b4_mwa[i] <= 64'(n_f[i]) * 64'($signed({1'b0, r_b3.c.inv}));
        end

        r_b5.alive   <= r_b4.c.alive;
        r_b5.vx      <= r_b4.c.vx;
        r_b5.vy      <= r_b4.c.vy;
        r_b5.vz      <= r_b4.c.vz;
        r_b5.gx      <= r_b4.gx;
        r_b5.gy      <= r_b4.gy;
        r_b5.gz      <= r_b4.gz;
        r_b5.wx      <= n_wa[0];
        r_b5.wy      <= n_wa[1];
        r_b5.wz      <= n_wa[2];
        r_b5.dt      <= r_b4.c.dt;
        r_b5.rel_len <= r_b4_len;

        r_b6       <= r_b5;
        r_b6_sq[0] <= 64'(abs32(r_b5.wx)) * 64'(abs32(r_b5.wx));
        r_b6_sq[1] <= 64'(abs32(r_b5.wy)) * 64'(abs32(r_b5.wy));
        r_b6_sq[2] <= 64'(abs32(r_b5.wz)) * 64'(abs32(r_b5.wz));

        r_b7     <= r_b6;
        r_b7_wa2 <= r_b6_sq[0] + r_b6_sq[1] + r_b6_sq[2];
    end

    // Hold the particle while the drag magnitude root settles
    always_ff @(posedge i_clk) begin
        r_dly2[0] <= r_b7;
        for (int j = 1; j < D2; j++) begin
            r_dly2[j] <= r_dly2[j-1];
        end
    end

    pfds_sqrt u_sqrt_acc (
        .i_clk  (i_clk),
        .i_rad  (r_b7_wa2),
        .o_root (w_acc_len)
    );

    // Overshoot test: |rel| < dt * |drag accel|
    assign n_lim = ({r_dly2[D2-1].rel_len, 16'd0} < 48'(r_dly2[D2-1].dt) * 48'(w_acc_len))
                   && (w_acc_len != '0);

    always_ff @(posedge i_clk) begin
        r_c1.alive <= r_dly2[D2-1].alive;
        r_c1.lim   <= n_lim;
        r_c1.vx    <= r_dly2[D2-1].vx;
        r_c1.vy    <= r_dly2[D2-1].vy;
        r_c1.vz    <= r_dly2[D2-1].vz;
        r_c1.wx    <= r_dly2[D2-1].wx;
        r_c1.wy    <= r_dly2[D2-1].wy;
        r_c1.wz    <= r_dly2[D2-1].wz;
        r_c1.gdx   <= 49'(r_dly2[D2-1].gx) * 49'($signed({1'b0, r_dly2[D2-1].dt}));
        r_c1.gdy   <= 49'(r_dly2[D2-1].gy) * 49'($signed({1'b0, r_dly2[D2-1].dt}));
        r_c1.gdz   <= 49'(r_dly2[D2-1].gz) * 49'($signed({1'b0, r_dly2[D2-1].dt}));
        r_c1.dt    <= r_dly2[D2-1].dt;
        r_c1_num   <= 48'(r_dly2[D2-1].rel_len) * 48'(Q_CUT);
        r_c1_den   <= w_acc_len;
    end

    // Cut drag step; quotient fits 16 bits whenever the step is limited
    pfds_div u_div (
        .i_clk (i_clk),
        .i_num (r_c1_num),
        .i_den (r_c1_den),
        .o_quo (w_quo)
    );

    always_ff @(posedge i_clk) begin
        r_dly3[0] <= r_c1;
        for (int j = 1; j < DV_LAT; j++) begin
            r_dly3[j] <= r_dly3[j-1];
        end
    end

    assign n_cdt = r_dly3[DV_LAT-1].lim ? w_quo : r_dly3[DV_LAT-1].dt;

    always_ff @(posedge i_clk) begin
        r_d1.alive <= r_dly3[DV_LAT-1].alive;
        r_d1.lim   <= r_dly3[DV_LAT-1].lim;
        r_d1.cdt   <= n_cdt;
        r_d1.dt    <= r_dly3[DV_LAT-1].dt;
        r_d1.vx    <= r_dly3[DV_LAT-1].vx;
        r_d1.vy    <= r_dly3[DV_LAT-1].vy;
        r_d1.vz    <= r_dly3[DV_LAT-1].vz;
        r_d1.gqx   <= 34'(rnd_s(64'(r_dly3[DV_LAT-1].gdx)));
        r_d1.gqy   <= 34'(rnd_s(64'(r_dly3[DV_LAT-1].gdy)));
        r_d1.gqz   <= 34'(rnd_s(64'(r_dly3[DV_LAT-1].gdz)));
        r_d1.mdx   <= 49'(r_dly3[DV_LAT-1].wx) * 49'($signed({1'b0, n_cdt}));
        r_d1.mdy   <= 49'(r_dly3[DV_LAT-1].wy) * 49'($signed({1'b0, n_cdt}));
        r_d1.mdz   <= 49'(r_dly3[DV_LAT-1].wz) * 49'($signed({1'b0, n_cdt}));
    end

    // Final sum, saturated once; a dead particle passes through
    assign n_nv[0] = sat_s32(64'(r_d1.vx) + 64'(r_d1.gqx) + rnd_s(64'(r_d1.mdx)));
    assign n_nv[1] = sat_s32(64'(r_d1.vy) + 64'(r_d1.gqy) + rnd_s(64'(r_d1.mdy)));
    assign n_nv[2] = sat_s32(64'(r_d1.vz) + 64'(r_d1.gqz) + rnd_s(64'(r_d1.mdz)));

    always_comb begin
        if (r_d1.alive) begin
            n_res.new_vel_x         = n_nv[0];
            n_res.new_vel_y         = n_nv[1];
            n_res.new_vel_z         = n_nv[2];
            n_res.drag_step_limited = r_d1.lim;
        end else begin
            n_res.new_vel_x         = r_d1.vx;
            n_res.new_vel_y         = r_d1.vy;
            n_res.new_vel_z         = r_d1.vz;
            n_res.drag_step_limited = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_res;
    end

    assign o_valid = r_vld[LAT-1];

`ifndef NO_ASSERTIONS
    // A cut drag step is always shorter than the frame step
    a_cut_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-2] && r_d1.lim |-> (r_d1.cdt < r_d1.dt))
        else $error("cut drag step not below time step");

    // No transaction leaves the block right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // A strobed limit flag comes from a particle that was limited in r_d1
    a_lim_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.drag_step_limited |-> $past(r_d1.lim && r_d1.alive))
        else $error("limit flag without limited live particle");
`endif

endmodule
